FILE: sv/ctok_pkg.sv
// Shared types and constants for the C source tokenizer.
// No dependencies; every other file of the block imports this package.
package ctok_pkg;

   localparam int LINE_BITS   = 20;
   localparam int COLUMN_BITS = 16;
   localparam int LENGTH_BITS = 16;
   localparam int MAX_RESULTS = 3;

   localparam logic [6:0] KIND_DOT     = 7'd13;
   localparam logic [6:0] KIND_KW_BASE = 7'd48;
   localparam logic [6:0] KIND_IDENT   = 7'd78;
   localparam logic [6:0] KIND_NUMBER  = 7'd79;
   localparam logic [6:0] KIND_CHAR    = 7'd80;
   localparam logic [6:0] KIND_STRING  = 7'd81;
   localparam logic [6:0] KIND_UNKNOWN = 7'd82;
   localparam logic [6:0] KIND_EOF     = 7'd83;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_OPEN_BLOCK  = 3'd1;
   localparam logic [2:0] ERR_EMPTY_CHAR  = 3'd2;
   localparam logic [2:0] ERR_OPEN_CHAR   = 3'd3;
   localparam logic [2:0] ERR_OPEN_STRING = 3'd4;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_PUNCT, MODE_IDENT, MODE_NUMBER,
      MODE_CHAR, MODE_STRING, MODE_LINEC, MODE_BLOCKC
   } scan_mode_type;

   typedef struct packed {
      scan_mode_type          mode;
      logic [7:0]             held_char;
      logic                   held_two;
      logic [63:0]            kw_shift;
      logic [LINE_BITS-1:0]   tok_line;
      logic [COLUMN_BITS-1:0] tok_col;
      logic [LENGTH_BITS-1:0] len;
      logic [7:0]             prev_char;
      logic                   flag;
   } scan_state_type;

   typedef struct packed {
      logic [6:0]             kind;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] col;
      logic [LENGTH_BITS-1:0] len;
      logic [2:0]             err;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [1:0]                   count;
   } bundle_type;

   localparam scan_state_type SCAN_RESET = '{
      mode: MODE_IDLE, held_char: 8'd0, held_two: 1'b0, kw_shift: 64'd0,
      tok_line: LINE_BITS'(1), tok_col: COLUMN_BITS'(1), len: '0,
      prev_char: 8'd0, flag: 1'b0};

endpackage

FILE: sv/c_source_tokenizer_core.sv
// Top level of the C source tokenizer: scan state registers and the result buffer.
// Depends on ctok_pkg, ctok_step and ctok_outbuf.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | in_byte, end_of_input
//  rsp     | out       | rsp_valid/rsp_stall  | token fields, last_of_step
//
// A byte is taken when the result buffer is free, and its tokens (none to three) are
// registered at that edge; the next byte can be taken in the next cycle while the buffer stays free.
// The result buffer hands out one token per cycle while the result side does not stall, so a
// byte that makes two or three tokens holds the input until its last token is being taken.
// Reset (synchronous, active high) returns the scanner to line 1, column 1 and
// empties the result buffer.
// A stall on the result side holds the buffered tokens; input stalls once the
// buffer cannot be refilled at the next edge.
module c_source_tokenizer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_end_of_input,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [6:0]                       rsp_token_kind,
   output logic [ctok_pkg::LINE_BITS-1:0]   rsp_start_line,
   output logic [ctok_pkg::COLUMN_BITS-1:0] rsp_start_column,
   output logic [ctok_pkg::LENGTH_BITS-1:0] rsp_token_length,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_last_of_step
);
   import ctok_pkg::*;

   scan_state_type         scan_ff, scan_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   bundle_type             bundle;
   result_type             out_res;
   logic                   free;
   logic                   accept;

   // A transaction is taken only when the result buffer can take its tokens.
   assign req_stall = !free;
   assign accept = req_valid && free;

   ctok_step u_step (
      .state_ff     (scan_ff),
      .cur_line     (line_ff),
      .cur_col      (col_ff),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .state_in     (scan_in),
      .line_in      (line_in),
      .col_in       (col_in),
      .bundle       (bundle)
   );

   // Scan state advances on every accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= SCAN_RESET;
         line_ff <= LINE_BITS'(1);
         col_ff <= COLUMN_BITS'(1);
      end else if (accept) begin
         scan_ff <= scan_in;
         line_ff <= line_in;
         col_ff <= col_in;
      end
   end

   ctok_outbuf u_outbuf (
      .clock       (clock),
      .reset       (reset),
      .load        (accept && bundle.count != 2'd0),
      .load_bundle (bundle),
      .free        (free),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_res     (out_res),
      .out_last    (rsp_last_of_step)
   );

   assign rsp_token_kind = out_res.kind;
   assign rsp_start_line = out_res.line;
   assign rsp_start_column = out_res.col;
   assign rsp_token_length = out_res.len;
   assign rsp_error_code = out_res.err;

endmodule

FILE: sv/ctok_step.sv
// Combinational scan step: next scan state and up to three tokens for one byte.
// Depends on ctok_pkg.
module ctok_step (
   input  ctok_pkg::scan_state_type         state_ff,
   input  logic [ctok_pkg::LINE_BITS-1:0]   cur_line,
   input  logic [ctok_pkg::COLUMN_BITS-1:0] cur_col,
   input  logic [7:0]                       in_byte,
   input  logic                             end_of_input,
   output ctok_pkg::scan_state_type         state_in,
   output logic [ctok_pkg::LINE_BITS-1:0]   line_in,
   output logic [ctok_pkg::COLUMN_BITS-1:0] col_in,
   output ctok_pkg::bundle_type             bundle
);
   import ctok_pkg::*;

   typedef struct packed {
      scan_state_type st;
      logic           emit;
      result_type     res;
      logic           again;
   } feed_type;

   localparam logic [63:0] KW_TABLE [30] = '{
      "break", "case", "char", "const", "continue", "default", "do", "double",
      "else", "enum", "extern", "float", "for", "goto", "if", "inline", "int",
      "long", "return", "short", "signed", "sizeof", "static", "struct",
      "switch", "typedef", "union", "unsigned", "void", "while"};

   function automatic logic is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_word(logic [7:0] b);
      return is_alpha(b) || is_digit(b) || b == "_";
   endfunction

   // Single-character punctuators; bit 7 flags a match.
   function automatic logic [7:0] punct1(logic [7:0] a);
      logic [7:0] k;
      case (a)
         "?": k = 8'h80 | 8'd0;
         "(": k = 8'h80 | 8'd1;
         ")": k = 8'h80 | 8'd2;
         "[": k = 8'h80 | 8'd3;
         "]": k = 8'h80 | 8'd4;
         "{": k = 8'h80 | 8'd5;
         "}": k = 8'h80 | 8'd6;
         "~": k = 8'h80 | 8'd7;
         ";": k = 8'h80 | 8'd8;
         ",": k = 8'h80 | 8'd9;
         ":": k = 8'h80 | 8'd10;
         "=": k = 8'h80 | 8'd11;
         ".": k = 8'h80 | 8'd13;
         "&": k = 8'h80 | 8'd15;
         "*": k = 8'h80 | 8'd18;
         "+": k = 8'h80 | 8'd20;
         "-": k = 8'h80 | 8'd23;
         "!": k = 8'h80 | 8'd27;
         "/": k = 8'h80 | 8'd29;
         "%": k = 8'h80 | 8'd31;
         "<": k = 8'h80 | 8'd33;
         ">": k = 8'h80 | 8'd37;
         "^": k = 8'h80 | 8'd41;
         "|": k = 8'h80 | 8'd43;
         "#": k = 8'h80 | 8'd46;
         default: k = 8'h00;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] punct2(logic [7:0] a, logic [7:0] b);
      logic [7:0] k;
      case ({a, b})
         "==": k = 8'h80 | 8'd12;
         "&&": k = 8'h80 | 8'd16;
         "&=": k = 8'h80 | 8'd17;
         "*=": k = 8'h80 | 8'd19;
         "++": k = 8'h80 | 8'd21;
         "+=": k = 8'h80 | 8'd22;
         "--": k = 8'h80 | 8'd24;
         "->": k = 8'h80 | 8'd25;
         "-=": k = 8'h80 | 8'd26;
         "!=": k = 8'h80 | 8'd28;
         "/=": k = 8'h80 | 8'd30;
         "%=": k = 8'h80 | 8'd32;
         "<<": k = 8'h80 | 8'd34;
         "<=": k = 8'h80 | 8'd35;
         ">>": k = 8'h80 | 8'd38;
         ">=": k = 8'h80 | 8'd39;
         "^=": k = 8'h80 | 8'd42;
         "|=": k = 8'h80 | 8'd44;
         "||": k = 8'h80 | 8'd45;
         "##": k = 8'h80 | 8'd47;
         default: k = 8'h00;
      endcase
      return k;
   endfunction

   function automatic logic [6:0] punct3(logic [7:0] a);
      logic [6:0] k;
      case (a)
         ".": k = 7'd14;
         "<": k = 7'd36;
         default: k = 7'd40;
      endcase
      return k;
   endfunction

   function automatic logic is_prefix(logic [7:0] a);
      return a == "=" || a == "." || a == "&" || a == "*" || a == "+" || a == "-" ||
             a == "!" || a == "/" || a == "%" || a == "<" || a == ">" || a == "^" ||
             a == "|" || a == "#";
   endfunction

   function automatic logic [LENGTH_BITS-1:0] sat_len(logic [LENGTH_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [COLUMN_BITS-1:0] sat_col(logic [COLUMN_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_line(logic [LINE_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [6:0] ident_kind(scan_state_type s);
      logic [6:0] k;
      k = KIND_IDENT;
      if (s.len <= LENGTH_BITS'(8)) begin
         for (int i = 0; i < 30; i++) begin
            if (KW_TABLE[i] == s.kw_shift) k = KIND_KW_BASE + 7'(i);
         end
      end
      return k;
   endfunction

   function automatic result_type tok(scan_state_type s, logic [6:0] kind, logic [2:0] err);
      return '{kind: kind, line: s.tok_line, col: s.tok_col, len: s.len, err: err};
   endfunction

   // One pass over the byte; again asks for the same byte to be handled once more.
   function automatic feed_type feed_once(scan_state_type s, logic [7:0] b,
                                          logic [LINE_BITS-1:0] cl,
                                          logic [COLUMN_BITS-1:0] cc);
      feed_type   f;
      logic [7:0] c;
      logic [7:0] k;
      f = '{st: s, emit: 1'b0, res: '0, again: 1'b0};
      c = s.held_char;
      k = 8'd0;
      case (s.mode)
         MODE_PUNCT: begin
            if (s.held_two) begin
               if ((c == "." && b == ".") || (c != "." && b == "=")) begin
                  f.st.len = LENGTH_BITS'(3);
                  f.emit = 1'b1;
                  f.res = tok(f.st, punct3(c), ERR_NONE);
                  f.st.mode = MODE_IDLE;
               end else if (c == ".") begin
                  // The first of two held dots leaves as a dot of its own.
                  f.emit = 1'b1;
                  f.res = '{kind: KIND_DOT, line: s.tok_line, col: s.tok_col,
                            len: LENGTH_BITS'(1), err: ERR_NONE};
                  f.st.tok_col = sat_col(s.tok_col);
                  f.st.held_two = 1'b0;
                  f.st.len = LENGTH_BITS'(1);
                  f.again = 1'b1;
               end else begin
                  f.emit = 1'b1;
                  f.res = tok(s, punct2(c, c)[6:0], ERR_NONE);
                  f.st.mode = MODE_IDLE;
                  f.again = 1'b1;
               end
            end else if (c == "." && is_digit(b)) begin
               f.st.mode = MODE_NUMBER;
               f.st.len = sat_len(s.len);
               f.st.prev_char = b;
            end else if (c == b && (c == "." || c == "<" || c == ">")) begin
               f.st.held_two = 1'b1;
               f.st.len = sat_len(s.len);
            end else if (c == "/" && (b == "/" || b == "*")) begin
               f.st.mode = (b == "/") ? MODE_LINEC : MODE_BLOCKC;
               f.st.len = sat_len(s.len);
               f.st.flag = 1'b0;
            end else begin
               k = punct2(c, b);
               if (k[7]) begin
                  f.st.len = sat_len(s.len);
                  f.emit = 1'b1;
                  f.res = tok(f.st, k[6:0], ERR_NONE);
                  f.st.mode = MODE_IDLE;
               end else begin
                  f.emit = 1'b1;
                  f.res = tok(s, punct1(c)[6:0], ERR_NONE);
                  f.st.mode = MODE_IDLE;
                  f.again = 1'b1;
               end
            end
         end
         MODE_IDENT: begin
            if (is_word(b)) begin
               f.st.len = sat_len(s.len);
               f.st.kw_shift = {s.kw_shift[55:0], b};
            end else begin
               f.emit = 1'b1;
               f.res = tok(s, ident_kind(s), ERR_NONE);
               f.st.mode = MODE_IDLE;
               f.again = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_word(b) || b == "." || ((b == "+" || b == "-") &&
                ((s.prev_char | 8'h20) == "e" || (s.prev_char | 8'h20) == "p"))) begin
               f.st.len = sat_len(s.len);
               f.st.prev_char = b;
            end else begin
               f.emit = 1'b1;
               f.res = tok(s, KIND_NUMBER, ERR_NONE);
               f.st.mode = MODE_IDLE;
               f.again = 1'b1;
            end
         end
         MODE_CHAR, MODE_STRING: begin
            if (s.flag) begin
               f.st.flag = 1'b0;
               f.st.len = sat_len(s.len);
            end else if (b == 8'h0A) begin
               f.emit = 1'b1;
               f.res = tok(s, KIND_UNKNOWN,
                           (s.mode == MODE_CHAR) ? ERR_OPEN_CHAR : ERR_OPEN_STRING);
               f.st.mode = MODE_IDLE;
            end else begin
               f.st.len = sat_len(s.len);
               if (s.mode == MODE_CHAR && b == "'") begin
                  f.emit = 1'b1;
                  f.res = (f.st.len == LENGTH_BITS'(2)) ?
                          tok(f.st, KIND_UNKNOWN, ERR_EMPTY_CHAR) :
                          tok(f.st, KIND_CHAR, ERR_NONE);
                  f.st.mode = MODE_IDLE;
               end else if (s.mode == MODE_STRING && b == "\"") begin
                  f.emit = 1'b1;
                  f.res = tok(f.st, KIND_STRING, ERR_NONE);
                  f.st.mode = MODE_IDLE;
               end else if (b == "\\") begin
                  f.st.flag = 1'b1;
               end
            end
         end
         MODE_LINEC: begin
            f.st.len = sat_len(s.len);
            if (b == 8'h0A) f.st.mode = MODE_IDLE;
         end
         MODE_BLOCKC: begin
            f.st.len = sat_len(s.len);
            if (s.flag && b == "/") f.st.mode = MODE_IDLE;
            else f.st.flag = (b == "*");
         end
         default: begin
            f.st.mode = MODE_IDLE;
            k = punct1(b);
            if (is_alpha(b) || is_digit(b) || b == "_" || b == "'" || b == "\"" || k[7]) begin
               f.st.tok_line = cl;
               f.st.tok_col = cc;
               f.st.len = LENGTH_BITS'(1);
               f.st.flag = 1'b0;
            end
            if (is_alpha(b) || b == "_") begin
               f.st.mode = MODE_IDENT;
               f.st.kw_shift = {56'd0, b};
            end else if (is_digit(b)) begin
               f.st.mode = MODE_NUMBER;
               f.st.prev_char = b;
            end else if (b == "'") begin
               f.st.mode = MODE_CHAR;
            end else if (b == "\"") begin
               f.st.mode = MODE_STRING;
            end else if (k[7]) begin
               f.st.mode = MODE_PUNCT;
               f.st.held_char = b;
               f.st.held_two = 1'b0;
               if (!is_prefix(b)) begin
                  f.emit = 1'b1;
                  f.res = tok(f.st, k[6:0], ERR_NONE);
                  f.st.mode = MODE_IDLE;
               end
            end
         end
      endcase
      return f;
   endfunction

   feed_type       f0, f1, f2;
   result_type     list [MAX_RESULTS];
   logic           list_ok [MAX_RESULTS];
   scan_state_type fs;
   logic [1:0]     cnt;

   always_comb begin
      f0 = feed_once(state_ff, in_byte, cur_line, cur_col);
      f1 = f0.again ? feed_once(f0.st, in_byte, cur_line, cur_col) : '0;
      f2 = (f0.again && f1.again) ? feed_once(f1.st, in_byte, cur_line, cur_col) : '0;
      fs = state_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         list[i] = '0;
         list_ok[i] = 1'b0;
      end
      if (end_of_input) begin
         // Flush whatever token is open, then the end-of-file token.
         case (state_ff.mode)
            MODE_PUNCT: begin
               list_ok[0] = 1'b1;
               if (state_ff.held_two && state_ff.held_char == ".") begin
                  list[0] = '{kind: KIND_DOT, line: state_ff.tok_line,
                              col: state_ff.tok_col, len: LENGTH_BITS'(1), err: ERR_NONE};
                  list[1] = '{kind: KIND_DOT, line: state_ff.tok_line,
                              col: sat_col(state_ff.tok_col), len: LENGTH_BITS'(1),
                              err: ERR_NONE};
                  list_ok[1] = 1'b1;
               end else if (state_ff.held_two) begin
                  list[0] = tok(state_ff, punct2(state_ff.held_char,
                                                 state_ff.held_char)[6:0], ERR_NONE);
               end else begin
                  list[0] = tok(state_ff, punct1(state_ff.held_char)[6:0], ERR_NONE);
               end
            end
            MODE_IDENT: begin
               list_ok[0] = 1'b1;
               list[0] = tok(state_ff, ident_kind(state_ff), ERR_NONE);
            end
            MODE_NUMBER: begin
               list_ok[0] = 1'b1;
               list[0] = tok(state_ff, KIND_NUMBER, ERR_NONE);
            end
            MODE_CHAR: begin
               list_ok[0] = 1'b1;
               list[0] = tok(state_ff, KIND_UNKNOWN, ERR_OPEN_CHAR);
            end
            MODE_STRING: begin
               list_ok[0] = 1'b1;
               list[0] = tok(state_ff, KIND_UNKNOWN, ERR_OPEN_STRING);
            end
            MODE_BLOCKC: begin
               list_ok[0] = 1'b1;
               list[0] = tok(state_ff, KIND_UNKNOWN, ERR_OPEN_BLOCK);
            end
            default: begin
               list_ok[0] = 1'b0;
            end
         endcase
         list_ok[2] = 1'b1;
         list[2] = '{kind: KIND_EOF, line: cur_line, col: cur_col,
                     len: LENGTH_BITS'(1), err: ERR_NONE};
         fs = SCAN_RESET;
         line_in = LINE_BITS'(1);
         col_in = COLUMN_BITS'(1);
      end else begin
         list[0] = f0.res;
         list_ok[0] = f0.emit;
         list[1] = f1.res;
         list_ok[1] = f0.again && f1.emit;
         list[2] = f2.res;
         list_ok[2] = f0.again && f1.again && f2.emit;
         fs = f0.again ? (f1.again ? f2.st : f1.st) : f0.st;
         if (in_byte == 8'h0A) begin
            line_in = sat_line(cur_line);
            col_in = COLUMN_BITS'(1);
         end else begin
            line_in = cur_line;
            col_in = sat_col(cur_col);
         end
      end
      // Pack the emitted tokens in order.
      bundle = '0;
      cnt = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (list_ok[i]) begin
            bundle.res[cnt] = list[i];
            cnt = cnt + 2'd1;
         end
      end
      bundle.count = cnt;
      state_in = fs;
   end

endmodule

FILE: sv/ctok_outbuf.sv
// Result buffer: holds the tokens of one byte and hands them out one per cycle unless stalled.
// Depends on ctok_pkg.
module ctok_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ctok_pkg::bundle_type load_bundle,
   output logic                 free,
   output logic                 out_valid,
   input  logic                 out_stall,
   output ctok_pkg::result_type out_res,
   output logic                 out_last
);
   import ctok_pkg::*;

   result_type [MAX_RESULTS-1:0] slots_ff, slots_in;
   logic [1:0]                   count_ff, count_in;
   logic [1:0]                   head_ff, head_in;
   logic                         take;

   assign out_valid = (count_ff != 2'd0);
   assign take = out_valid && !out_stall;
   assign free = (count_ff == 2'd0) || (count_ff == 2'd1 && !out_stall);
   assign out_res = slots_ff[head_ff];
   assign out_last = (count_ff == 2'd1);

   always_comb begin
      slots_in = slots_ff;
      count_in = count_ff;
      head_in = head_ff;
      if (take) begin
         count_in = count_ff - 2'd1;
         head_in = head_ff + 2'd1;
      end
      if (load) begin
         slots_in = load_bundle.res;
         count_in = load_bundle.count;
         head_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         count_ff <= 2'd0;
         head_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         head_ff <= head_in;
      end
   end

endmodule

FILE: sv/ctok_checker.sv
// Port-level checks of the C source tokenizer, bound to the top level.
// Depends on ctok_pkg and c_source_tokenizer_core.
module ctok_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             req_end_of_input,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [6:0]                       rsp_token_kind,
   input logic                             rsp_last_of_step
);
   import ctok_pkg::*;

   // A stalled token stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind))
      else $error("stalled token changed");

   // The end marker always yields at least the end-of-file token.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_input |=> rsp_valid)
      else $error("no token after end of input");

   // A token that is not the last of its byte is followed by another.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_step |=> rsp_valid)
      else $error("tokens of one byte cut short");

   // With nothing buffered the input is never held off.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty buffer");

endmodule

bind c_source_tokenizer_core ctok_checker u_ctok_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_end_of_input (req_end_of_input),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_last_of_step (rsp_last_of_step)
);

FILE: test/tb.sv
// Self-checking testbench for the C source tokenizer core.
// Depends on ctok_pkg and c_source_tokenizer_core; a built-in scanner model predicts every token.
`timescale 1ns / 1ps

module tb;
   import ctok_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_in_byte;
   logic                   req_end_of_input;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [6:0]             rsp_token_kind;
   logic [LINE_BITS-1:0]   rsp_start_line;
   logic [COLUMN_BITS-1:0] rsp_start_column;
   logic [LENGTH_BITS-1:0] rsp_token_length;
   logic [2:0]             rsp_error_code;
   logic                   rsp_last_of_step;

   c_source_tokenizer_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_in_byte(req_in_byte), .req_end_of_input(req_end_of_input),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind), .rsp_start_line(rsp_start_line),
      .rsp_start_column(rsp_start_column), .rsp_token_length(rsp_token_length),
      .rsp_error_code(rsp_error_code), .rsp_last_of_step(rsp_last_of_step)
   );

   // A token the scanner model says must come out, and whether it closes its byte.
   typedef struct {
      result_type tok;
      logic       last;
   } token_due_type;

   token_due_type tokens_due[$];
   result_type    step_tokens[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 0;
   int            stall_pct = 0;

   // Punctuator spellings in kind order; the index is the kind code.
   string punct_tab[48] = '{
      "?", "(", ")", "[", "]", "{", "}", "~", ";", ",", ":",
      "=", "==", ".", "...", "&", "&&", "&=", "*", "*=", "+", "++", "+=",
      "-", "--", "->", "-=", "!", "!=", "/", "/=", "%", "%=",
      "<", "<<", "<=", "<<=", ">", ">>", ">=", ">>=", "^", "^=",
      "|", "|=", "||", "#", "##"};

   // Keywords in alphabetical order, starting at KIND_KW_BASE.
   string kw_tab[30] = '{
      "break", "case", "char", "const", "continue", "default", "do", "double",
      "else", "enum", "extern", "float", "for", "goto", "if", "inline", "int",
      "long", "return", "short", "signed", "sizeof", "static", "struct",
      "switch", "typedef", "union", "unsigned", "void", "while"};

   // Scanner model state. The token start, length and mode describe the token
   // being built; the current line and column track the next byte.
   scan_mode_type          sc_mode;
   logic [7:0]             sc_held;
   int                     sc_held_cnt;
   logic [63:0]            sc_kw;
   logic [LINE_BITS-1:0]   sc_tok_line, sc_cur_line;
   logic [COLUMN_BITS-1:0] sc_tok_col, sc_cur_col;
   logic [LENGTH_BITS-1:0] sc_len;
   logic [7:0]             sc_prev;
   logic                   sc_flag;

   // ---------------------------------------------------------------------
   // Clock, reset and cycle watchdog.
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The receiver decides its stall for the next edge on every falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // ---------------------------------------------------------------------
   // Scanner model.
   // ---------------------------------------------------------------------
   function automatic logic [LINE_BITS-1:0] inc_line(logic [LINE_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [COLUMN_BITS-1:0] inc_col(logic [COLUMN_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic void clear_scanner();
      sc_mode = MODE_IDLE;
      sc_held = 8'd0;
      sc_held_cnt = 0;
      sc_kw = '0;
      sc_tok_line = 1;
      sc_tok_col = 1;
      sc_len = '0;
      sc_cur_line = 1;
      sc_cur_col = 1;
      sc_prev = 8'd0;
      sc_flag = 1'b0;
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_word(logic [7:0] b);
      return is_alpha(b) || is_digit(b) || b == "_";
   endfunction

   // Kind of the punctuator spelled by the first n of a, b, c; -1 if none.
   function automatic int punct_kind(logic [7:0] a, logic [7:0] b, logic [7:0] c, int n);
      string t;
      for (int i = 0; i < 48; i++) begin
         t = punct_tab[i];
         if (t.len() == n && t[0] == a && (n < 2 || t[1] == b) && (n < 3 || t[2] == c))
            return i;
      end
      return -1;
   endfunction

   function automatic bit starts_longer(logic [7:0] a);
      foreach (punct_tab[i])
         if (punct_tab[i].len() > 1 && punct_tab[i][0] == a) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void put_token(int kind, logic [LINE_BITS-1:0] ln,
                                     logic [COLUMN_BITS-1:0] col,
                                     logic [LENGTH_BITS-1:0] len, logic [2:0] err);
      result_type r;
      if (step_tokens.size() >= MAX_RESULTS) return;
      r.kind = 7'(kind);
      r.line = ln;
      r.col = col;
      r.len = len;
      r.err = err;
      step_tokens.push_back(r);
   endfunction

   function automatic void close_token(int kind, logic [2:0] err);
      put_token(kind, sc_tok_line, sc_tok_col, sc_len, err);
      sc_mode = MODE_IDLE;
   endfunction

   function automatic void open_token(scan_mode_type m);
      sc_mode = m;
      sc_tok_line = sc_cur_line;
      sc_tok_col = sc_cur_col;
      sc_len = 1;
      sc_flag = 1'b0;
   endfunction

   function automatic void grow_token();
      sc_len = (sc_len == '1) ? sc_len : sc_len + 1'b1;
   endfunction

   function automatic int word_kind();
      logic [63:0] v;
      if (sc_len <= 8) begin
         foreach (kw_tab[i]) begin
            v = '0;
            for (int j = 0; j < kw_tab[i].len(); j++) v = {v[55:0], 8'(kw_tab[i][j])};
            if (v == sc_kw) return int'(KIND_KW_BASE) + i;
         end
      end
      return int'(KIND_IDENT);
   endfunction

   // Two held dots that do not become an ellipsis: the first leaves as a dot.
   function automatic void release_first_dot();
      put_token(int'(KIND_DOT), sc_tok_line, sc_tok_col, 1, ERR_NONE);
      sc_tok_col = inc_col(sc_tok_col);
      sc_held_cnt = 1;
      sc_len = 1;
      sc_mode = MODE_PUNCT;
   endfunction

   // Consumes one byte in the current mode; returns 1 when the byte must be
   // looked at again because it ended the previous token.
   function automatic bit scan_byte(logic [7:0] b);
      logic [7:0] c;
      int         k;
      logic [7:0] pl;
      c = sc_held;
      pl = sc_prev | 8'h20;
      case (sc_mode)
         MODE_PUNCT: begin
            if (sc_held_cnt == 2) begin
               if ((c == "." && b == ".") || (c != "." && b == "=")) begin
                  sc_len = 3;
                  close_token(punct_kind(c, c, b, 3), ERR_NONE);
                  return 1'b0;
               end
               if (c == ".") begin
                  release_first_dot();
                  return 1'b1;
               end
               close_token(punct_kind(c, c, 0, 2), ERR_NONE);
               return 1'b1;
            end
            if (c == "." && is_digit(b)) begin
               sc_mode = MODE_NUMBER;
               grow_token();
               sc_prev = b;
               return 1'b0;
            end
            if (c == b && (c == "." || c == "<" || c == ">")) begin
               sc_held_cnt = 2;
               grow_token();
               return 1'b0;
            end
            if (c == "/" && (b == "/" || b == "*")) begin
               sc_mode = (b == "/") ? MODE_LINEC : MODE_BLOCKC;
               grow_token();
               sc_flag = 1'b0;
               return 1'b0;
            end
            k = punct_kind(c, b, 0, 2);
            if (k >= 0) begin
               grow_token();
               close_token(k, ERR_NONE);
               return 1'b0;
            end
            close_token(punct_kind(c, 0, 0, 1), ERR_NONE);
            return 1'b1;
         end
         MODE_IDENT: begin
            if (is_word(b)) begin
               grow_token();
               sc_kw = {sc_kw[55:0], b};
               return 1'b0;
            end
            close_token(word_kind(), ERR_NONE);
            return 1'b1;
         end
         MODE_NUMBER: begin
            // A sign continues a number only right after an exponent letter.
            if (is_word(b) || b == "." || ((b == "+" || b == "-") && (pl == "e" || pl == "p")))
            begin
               grow_token();
               sc_prev = b;
               return 1'b0;
            end
            close_token(int'(KIND_NUMBER), ERR_NONE);
            return 1'b1;
         end
         MODE_CHAR, MODE_STRING: begin
            if (sc_flag) begin
               sc_flag = 1'b0;
               grow_token();
               return 1'b0;
            end
            if (b == "\n") begin
               close_token(int'(KIND_UNKNOWN),
                           sc_mode == MODE_CHAR ? ERR_OPEN_CHAR : ERR_OPEN_STRING);
               return 1'b0;
            end
            grow_token();
            if (sc_mode == MODE_CHAR && b == "'") begin
               if (sc_len == 2) close_token(int'(KIND_UNKNOWN), ERR_EMPTY_CHAR);
               else close_token(int'(KIND_CHAR), ERR_NONE);
            end else if (sc_mode == MODE_STRING && b == "\"") begin
               close_token(int'(KIND_STRING), ERR_NONE);
            end else if (b == "\\") begin
               sc_flag = 1'b1;
            end
            return 1'b0;
         end
         MODE_LINEC: begin
            grow_token();
            if (b == "\n") sc_mode = MODE_IDLE;
            return 1'b0;
         end
         MODE_BLOCKC: begin
            grow_token();
            if (sc_flag && b == "/") sc_mode = MODE_IDLE;
            else sc_flag = (b == "*");
            return 1'b0;
         end
         default: begin
            sc_mode = MODE_IDLE;
            if (is_alpha(b) || b == "_") begin
               open_token(MODE_IDENT);
               sc_kw = 64'(b);
               return 1'b0;
            end
            if (is_digit(b)) begin
               open_token(MODE_NUMBER);
               sc_prev = b;
               return 1'b0;
            end
            if (b == "'") begin
               open_token(MODE_CHAR);
               return 1'b0;
            end
            if (b == "\"") begin
               open_token(MODE_STRING);
               return 1'b0;
            end
            k = punct_kind(b, 0, 0, 1);
            if (k < 0) return 1'b0;
            open_token(MODE_PUNCT);
            sc_held = b;
            sc_held_cnt = 1;
            if (!starts_longer(b)) close_token(k, ERR_NONE);
            return 1'b0;
         end
      endcase
   endfunction

   // Emits whatever token is still open when the buffer ends.
   function automatic void flush_open_token();
      case (sc_mode)
         MODE_PUNCT: begin
            if (sc_held_cnt == 2) begin
               if (sc_held == ".") begin
                  release_first_dot();
                  close_token(int'(KIND_DOT), ERR_NONE);
               end else begin
                  close_token(punct_kind(sc_held, sc_held, 0, 2), ERR_NONE);
               end
            end else begin
               close_token(punct_kind(sc_held, 0, 0, 1), ERR_NONE);
            end
         end
         MODE_IDENT:  close_token(word_kind(), ERR_NONE);
         MODE_NUMBER: close_token(int'(KIND_NUMBER), ERR_NONE);
         MODE_CHAR:   close_token(int'(KIND_UNKNOWN), ERR_OPEN_CHAR);
         MODE_STRING: close_token(int'(KIND_UNKNOWN), ERR_OPEN_STRING);
         MODE_BLOCKC: close_token(int'(KIND_UNKNOWN), ERR_OPEN_BLOCK);
         default: ;
      endcase
   endfunction

   // Predicts the tokens caused by one accepted transaction and queues them.
   function automatic void tokenize_byte(logic [7:0] b, logic eoi);
      int            guard;
      token_due_type due;
      step_tokens.delete();
      if (eoi) begin
         flush_open_token();
         put_token(int'(KIND_EOF), sc_cur_line, sc_cur_col, 1, ERR_NONE);
         clear_scanner();
      end else begin
         guard = 0;
         while (scan_byte(b) && guard < 4) guard++;
         if (b == "\n") begin
            sc_cur_line = inc_line(sc_cur_line);
            sc_cur_col = 1;
         end else begin
            sc_cur_col = inc_col(sc_cur_col);
         end
      end
      foreach (step_tokens[i]) begin
         due.tok = step_tokens[i];
         due.last = (i == step_tokens.size() - 1);
         tokens_due.push_back(due);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result checking.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Every transaction on the result channel is compared with the oldest
   // predicted token, one field at a time.
   always @(posedge clock) begin
      token_due_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tokens_due.size() == 0) begin
            report_mismatch("unexpected token kind", rsp_token_kind, -1);
         end else begin
            want = tokens_due.pop_front();
            if (rsp_token_kind !== want.tok.kind)
               report_mismatch("token_kind", rsp_token_kind, want.tok.kind);
            if (rsp_start_line !== want.tok.line)
               report_mismatch("start_line", rsp_start_line, want.tok.line);
            if (rsp_start_column !== want.tok.col)
               report_mismatch("start_column", rsp_start_column, want.tok.col);
            if (rsp_token_length !== want.tok.len)
               report_mismatch("token_length", rsp_token_length, want.tok.len);
            if (rsp_error_code !== want.tok.err)
               report_mismatch("error_code", rsp_error_code, want.tok.err);
            if (rsp_last_of_step !== want.last)
               report_mismatch("last_of_step", rsp_last_of_step, want.last);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------

   // Sends one input transaction. Valid is lowered only on idle cycles, so it
   // stays high between back-to-back transactions without a second assignment.
   task automatic send_byte(logic [7:0] b, logic eoi);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokenize_byte(b, eoi);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_byte(8'($urandom), 1'b1);
   endtask

   // Drops valid and waits for every predicted token to arrive.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_tokens();
      // Keyword, identifier, number with exponent sign and trailing dots, three-character shift,
      // empty char, escaped quote, open string at newline, odd bytes.
      send_text("sizeof x9 1e+5..<<=''\"\\\"\n'a'");
      send_byte(8'h0d, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_text("/*");
      send_end();
   endtask

   // A block comment left open at the end is reported at its start with its
   // length; a line comment left open ends quietly.
   task automatic test_open_comments();
      send_text("x");
      send_text("/*");
      for (int i = 0; i < 12; i++) send_byte(8'h2a ^ 8'(i[0]), 1'b0);
      send_text("a");
      send_end();
      send_text("//open");
      send_end();
   endtask

   // Random well-formed C fragments mixed with noise.
   task automatic test_random_source(int n_bytes);
      int    sent;
      int    pick;
      string s;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(19);
         s = "";
         case (pick)
            0, 1, 2: s = punct_tab[$urandom_range(47)];
            3, 4:    s = kw_tab[$urandom_range(29)];
            5:       s = {"_v", kw_tab[$urandom_range(29)]};
            6:       s = $sformatf("%0d", $urandom_range(99999));
            7:       s = $sformatf("0x%0hp-%0d.5E+1", $urandom_range(255), $urandom_range(9));
            8:       s = {"'", string'(8'($urandom_range(32, 126))), "'"};
            9:       s = "'\\''";
            10:      s = "\"ab\\\"c\\\nd\"";
            11:      s = {"\"", string'(8'($urandom_range(32, 126))), "\n"};
            12:      s = "/* x * / **/";
            13:      s = "// note\n";
            14, 15:  s = ($urandom_range(3) == 0) ? "\n" : " ";
            16:      s = "..";
            default: ;
         endcase
         if (pick >= 17) begin
            // Noise: any byte, or an end of buffer now and then.
            if ($urandom_range(7) == 0) send_end();
            else send_byte(8'($urandom), 1'b0);
            sent++;
         end else begin
            send_text(s);
            sent += s.len();
         end
      end
      send_end();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'd0;
      req_end_of_input = 1'b0;
      rsp_stall = 1'b0;
      clear_scanner();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_tokens();
      test_open_comments();

      test_random_source(90);
      // The sender holds off until everything is out before the next phase.
      wait_drained();
      send_idle_pct = 88;
      test_random_source(90);
      send_idle_pct = 0;
      stall_pct = 88;
      test_random_source(90);
      send_idle_pct = 13;
      stall_pct = 13;
      test_random_source(90);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && tokens_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
